>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and held off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

>>> rtl/core/bfha_pkg.sv
// ---------------------------------------------------------------------------
// bfha_pkg
// shared types, microcode encodings and step addresses of the heap allocator
// ---------------------------------------------------------------------------
package bfha_pkg;

    localparam int HEAP_BYTES_DEF = 128;
    localparam int SIZE_W         = 7;
    localparam int WALK_W         = 8;
    localparam int UPC_W          = 5;

    typedef logic [3:0]       op_t;
    typedef logic [2:0]       cond_t;
    typedef logic [UPC_W-1:0] upc_t;
    typedef logic [1:0]       status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NO_FIT    = 2'd1;
    localparam status_t ST_NOT_BLOCK = 2'd2;

    localparam op_t OP_NONE       = 4'd0;
    localparam op_t OP_LOAD       = 4'd1;
    localparam op_t OP_ALLOC_EVAL = 4'd2;
    localparam op_t OP_ALLOC_HDR  = 4'd3;
    localparam op_t OP_ALLOC_REM  = 4'd4;
    localparam op_t OP_FREE_EVAL  = 4'd5;
    localparam op_t OP_FREE_CLR   = 4'd6;
    localparam op_t OP_FREE_MERGE = 4'd7;
    localparam op_t OP_CLR_NEXT   = 4'd8;
    localparam op_t OP_EMIT_ALLOC = 4'd9;
    localparam op_t OP_EMIT_NOFIT = 4'd10;
    localparam op_t OP_EMIT_NOTBLK = 4'd11;
    localparam op_t OP_EMIT_OK    = 4'd12;

    localparam cond_t C_NEVER     = 3'd0;
    localparam cond_t C_ALWAYS    = 3'd1;
    localparam cond_t C_NO_VALID  = 3'd2;
    localparam cond_t C_CMD_FREE  = 3'd3;
    localparam cond_t C_ADDR_END  = 3'd4;
    localparam cond_t C_NOT_FOUND = 3'd5;
    localparam cond_t C_NOT_HIT   = 3'd6;
    localparam cond_t C_NEXT_USED = 3'd7;

    localparam upc_t STEP_IDLE     = 5'd0;
    localparam upc_t STEP_DISPATCH = 5'd1;
    localparam upc_t STEP_A_CHK    = 5'd2;
    localparam upc_t STEP_A_EVAL   = 5'd3;
    localparam upc_t STEP_A_FIN    = 5'd4;
    localparam upc_t STEP_A_HDR    = 5'd5;
    localparam upc_t STEP_A_REM    = 5'd6;
    localparam upc_t STEP_E_NOFIT  = 5'd7;
    localparam upc_t STEP_E_ALLOC  = 5'd8;
    localparam upc_t STEP_E_NOTBLK = 5'd9;
    localparam upc_t STEP_F_CHK    = 5'd10;
    localparam upc_t STEP_F_EVAL   = 5'd11;
    localparam upc_t STEP_F_CLR    = 5'd12;
    localparam upc_t STEP_F_NEXT   = 5'd13;
    localparam upc_t STEP_F_MRG    = 5'd14;
    localparam upc_t STEP_F_ZAP    = 5'd15;
    localparam upc_t STEP_E_OK     = 5'd16;
    localparam upc_t STEP_LAST     = 5'd16;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  tgt;
        logic  wait_out;
    } ctl_word_t;

    typedef struct packed {
        logic cmd_free;
        logic addr_end;
        logic found;
        logic hit;
        logic next_used;
        logic out_busy;
    } dp_flags_t;

endpackage

>>> rtl/core/bfha_ucode_rom.sv
// ---------------------------------------------------------------------------
// bfha_ucode_rom
// control store: one control word per step of the allocate and free programs
// ---------------------------------------------------------------------------
module bfha_ucode_rom (
    input  bfha_pkg::upc_t      upc,
    output bfha_pkg::ctl_word_t ctl
);
    import bfha_pkg::*;

    always_comb
    begin
        unique case (upc)
            STEP_IDLE:     ctl = '{OP_LOAD,        C_NO_VALID,  STEP_IDLE,     1'b0};
            STEP_DISPATCH: ctl = '{OP_NONE,        C_CMD_FREE,  STEP_F_CHK,    1'b0};
            STEP_A_CHK:    ctl = '{OP_NONE,        C_ADDR_END,  STEP_A_FIN,    1'b0};
            STEP_A_EVAL:   ctl = '{OP_ALLOC_EVAL,  C_ALWAYS,    STEP_A_CHK,    1'b0};
            STEP_A_FIN:    ctl = '{OP_NONE,        C_NOT_FOUND, STEP_E_NOFIT,  1'b0};
            STEP_A_HDR:    ctl = '{OP_ALLOC_HDR,   C_NEVER,     STEP_IDLE,     1'b0};
            STEP_A_REM:    ctl = '{OP_ALLOC_REM,   C_ALWAYS,    STEP_E_ALLOC,  1'b0};
            STEP_E_NOFIT:  ctl = '{OP_EMIT_NOFIT,  C_ALWAYS,    STEP_IDLE,     1'b1};
            STEP_E_ALLOC:  ctl = '{OP_EMIT_ALLOC,  C_ALWAYS,    STEP_IDLE,     1'b1};
            STEP_E_NOTBLK: ctl = '{OP_EMIT_NOTBLK, C_ALWAYS,    STEP_IDLE,     1'b1};
            STEP_F_CHK:    ctl = '{OP_NONE,        C_ADDR_END,  STEP_E_NOTBLK, 1'b0};
            STEP_F_EVAL:   ctl = '{OP_FREE_EVAL,   C_NOT_HIT,   STEP_F_CHK,    1'b0};
            STEP_F_CLR:    ctl = '{OP_FREE_CLR,    C_ADDR_END,  STEP_E_OK,     1'b0};
            STEP_F_NEXT:   ctl = '{OP_NONE,        C_NEXT_USED, STEP_E_OK,     1'b0};
            STEP_F_MRG:    ctl = '{OP_FREE_MERGE,  C_NEVER,     STEP_IDLE,     1'b0};
            STEP_F_ZAP:    ctl = '{OP_CLR_NEXT,    C_NEVER,     STEP_IDLE,     1'b0};
            STEP_E_OK:     ctl = '{OP_EMIT_OK,     C_ALWAYS,    STEP_IDLE,     1'b1};
            default:       ctl = '{OP_NONE,        C_ALWAYS,    STEP_IDLE,     1'b0};
        endcase
    end

endmodule

>>> rtl/core/bfha_sequencer.sv
// ---------------------------------------------------------------------------
// bfha_sequencer
// step counter with conditional jumps, issues the datapath operation
// ---------------------------------------------------------------------------
module bfha_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  bfha_pkg::dp_flags_t flags,
    output bfha_pkg::op_t       op,
    output logic                in_ready
);
    import bfha_pkg::*;

    upc_t      upc_reg;
    upc_t      upc_next;
    ctl_word_t ctl;
    logic      hold;
    logic      take;

    bfha_ucode_rom u_rom (
        .upc (upc_reg),
        .ctl (ctl)
    );

    assign hold     = ctl.wait_out & flags.out_busy;
    assign op       = hold ? OP_NONE : ctl.op;
    assign in_ready = (ctl.op == OP_LOAD);

    always_comb
    begin
        unique case (ctl.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_VALID:  take = ~in_valid;
            C_CMD_FREE:  take = flags.cmd_free;
            C_ADDR_END:  take = flags.addr_end;
            C_NOT_FOUND: take = ~flags.found;
            C_NOT_HIT:   take = ~flags.hit;
            C_NEXT_USED: take = flags.next_used;
            default:     take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
            upc_next = upc_reg;
        else if (take)
            upc_next = ctl.tgt;
        else
            upc_next = upc_reg + upc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= STEP_IDLE;
        else
            upc_reg <= upc_next;
    end

endmodule

>>> rtl/core/bfha_datapath.sv
// ---------------------------------------------------------------------------
// bfha_datapath
// header memory, walk registers, best-fit tracking and result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bfha_datapath #(
    parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bfha_pkg::op_t       op,
    input  logic                in_valid,
    input  logic                in_cmd,
    input  logic [6:0]          in_request_size,
    input  logic [6:0]          in_free_address,
    input  logic                out_ready,
    output logic                out_valid,
    output bfha_pkg::status_t   out_status,
    output logic [6:0]          out_payload_address,
    output bfha_pkg::dp_flags_t flags
);
    import bfha_pkg::*;

    localparam int AW = (HEAP_BYTES > 1) ? $clog2(HEAP_BYTES) : 1;
    localparam logic [WALK_W-1:0] HEAP_END  = WALK_W'(HEAP_BYTES);
    localparam logic [7:0]        HDR_RESET = {SIZE_W'(HEAP_BYTES - 1), 1'b0};

    logic [7:0]        mem [HEAP_BYTES];

    logic              cmd_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [6:0]        paddr_reg;
    logic [WALK_W-1:0] addr_reg;
    logic [WALK_W-1:0] addr_next;
    logic [AW-1:0]     cur_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [AW-1:0]     best_reg;
    logic [SIZE_W-1:0] best_size_reg;
    logic [SIZE_W-1:0] best_diff_reg;
    logic              found_reg;
    logic              out_valid_reg;
    status_t           status_reg;
    logic [6:0]        pay_reg;
    logic              hdr0_valid_reg;
    logic [7:0]        rd_data_reg;
    logic              rd_zero_reg;

    logic [7:0]        hdr;
    logic [SIZE_W-1:0] hdr_size;
    logic [SIZE_W-1:0] diff;
    logic              better;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [7:0]        wdata;
    logic [AW-1:0]     raddr;
    logic              emit;

    // header 0 reads as one whole free block until first written
    assign hdr      = (rd_zero_reg && !hdr0_valid_reg) ? HDR_RESET : rd_data_reg;
    assign hdr_size = hdr[7:1];
    assign diff     = hdr_size - req_reg;
    assign better   = !hdr[0] && (hdr_size > req_reg) && (!found_reg || diff < best_diff_reg);
    assign addr_next = addr_reg + {1'b0, hdr_size} + WALK_W'(1);
    assign raddr    = addr_reg[AW-1:0];

    assign flags.cmd_free  = cmd_reg;
    assign flags.addr_end  = (addr_reg >= HEAP_END);
    assign flags.found     = found_reg;
    assign flags.hit       = ({1'b0, paddr_reg} == addr_reg + WALK_W'(1));
    assign flags.next_used = hdr[0];
    assign flags.out_busy  = out_valid_reg & ~out_ready;

    assign emit = (op == OP_EMIT_ALLOC) || (op == OP_EMIT_NOFIT) ||
                  (op == OP_EMIT_NOTBLK) || (op == OP_EMIT_OK);

    always_comb
    begin
        we    = 1'b0;
        waddr = cur_reg;
        wdata = 8'h00;
        case (op)
            OP_ALLOC_HDR:
            begin
                we    = 1'b1;
                waddr = best_reg;
                wdata = {req_reg, 1'b1};
            end
            OP_ALLOC_REM:
            begin
                we    = !flags.addr_end;
                waddr = addr_reg[AW-1:0];
                wdata = {best_size_reg - req_reg - SIZE_W'(1), 1'b0};
            end
            OP_FREE_CLR:
            begin
                we    = 1'b1;
                waddr = cur_reg;
                wdata = {size_reg, 1'b0};
            end
            OP_FREE_MERGE:
            begin
                we    = 1'b1;
                waddr = cur_reg;
                wdata = {size_reg + hdr_size + SIZE_W'(1), 1'b0};
            end
            OP_CLR_NEXT:
            begin
                we    = 1'b1;
                waddr = addr_reg[AW-1:0];
                wdata = 8'h00;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
        rd_zero_reg <= (raddr == '0);
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    cmd_reg   <= in_cmd;
                    req_reg   <= in_request_size;
                    paddr_reg <= in_free_address;
                    addr_reg  <= '0;
                end
            end
            OP_ALLOC_EVAL:
            begin
                addr_reg <= addr_next;
                if (better)
                begin
                    best_reg      <= addr_reg[AW-1:0];
                    best_size_reg <= hdr_size;
                    best_diff_reg <= diff;
                end
            end
            OP_ALLOC_HDR:
            begin
                addr_reg <= WALK_W'(best_reg) + {1'b0, req_reg} + WALK_W'(1);
            end
            OP_FREE_EVAL:
            begin
                cur_reg  <= addr_reg[AW-1:0];
                size_reg <= hdr_size;
                addr_reg <= addr_next;
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            status_reg <= (op == OP_EMIT_NOFIT)  ? ST_NO_FIT :
                          (op == OP_EMIT_NOTBLK) ? ST_NOT_BLOCK : ST_OK;
            pay_reg    <= (op == OP_EMIT_ALLOC) ? 7'(WALK_W'(best_reg) + WALK_W'(1)) : 7'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            hdr0_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == OP_LOAD && in_valid)
                found_reg <= 1'b0;
            else if (op == OP_ALLOC_EVAL && better)
                found_reg <= 1'b1;
            if (we && waddr == '0)
                hdr0_valid_reg <= 1'b1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_status          = status_reg;
    assign out_payload_address = pay_reg;

    `ASSERT_NEVER(a_write_in_heap, we && (WALK_W'(waddr) >= HEAP_END), "header write beyond heap")
    `ASSERT_PROP(a_fail_no_addr, (out_valid_reg && status_reg != ST_OK) |-> (pay_reg == 7'd0), "failed request carries an address")
    `ASSERT_PROP(a_best_surplus, found_reg |-> (best_diff_reg != '0), "best fit without surplus")

endmodule

>>> rtl/core/best_fit_heap_allocator.sv
// ---------------------------------------------------------------------------
// best_fit_heap_allocator
// best-fit heap allocator over an in-memory chain of one-byte block headers
// ---------------------------------------------------------------------------
// allocate: walks every block header, then writes the chosen header and the
// remainder header and registers the result; when nothing fits, it registers a no-fit result instead
// free: walks the headers up to and including the target, then clears it and merges a free successor
// one item in flight and one idle step, so an item is finished before the next
// one is taken; the header memory is read once per walk step
// reset: heap is one free block at once, no clearing pass, no output valid
module best_fit_heap_allocator #(
    parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // request_size[6:0], free_address[13:7], zero pad
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // payload_address[6:0], zero pad
    output logic [1:0]  m_tuser    // status
);
    import bfha_pkg::*;

    op_t       op;
    dp_flags_t flags;
    logic [6:0] pay;

    bfha_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .flags    (flags),
        .op       (op),
        .in_ready (s_tready)
    );

    bfha_datapath #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .op                  (op),
        .in_valid            (s_tvalid),
        .in_cmd              (s_tuser),
        .in_request_size     (s_tdata[6:0]),
        .in_free_address     (s_tdata[13:7]),
        .out_ready           (m_tready),
        .out_valid           (m_tvalid),
        .out_status          (m_tuser),
        .out_payload_address (pay),
        .flags               (flags)
    );

    assign m_tdata = {1'b0, pay};

endmodule

>>> sim/best_fit_heap_allocator_checker.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_checker
// stream monitor with its own header chain, compares every result item
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // request_size[6:0], free_address[13:7], zero pad
    input  logic        s_tuser,   // cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // payload_address[6:0], zero pad
    input  logic [1:0]  m_tuser,   // status
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import bfha_pkg::*;

    localparam int HEAP = HEAP_BYTES_DEF;

    typedef struct packed {
        status_t    status;
        logic [6:0] paddr;
    } reply_t;

    logic [7:0] hdr_mem [HEAP];
    reply_t     reply_q [$];
    reply_t     want;

    wire cmd_is_free = s_tuser;

    function automatic void heap_clear();
        for (int i = 0; i < HEAP; i++)
            hdr_mem[i] = 8'h00;
        hdr_mem[0] = {7'(HEAP - 1), 1'b0};
    endfunction

    function automatic int block_len(int a);
        return int'(hdr_mem[a][7:1]);
    endfunction

    function automatic reply_t best_fit_alloc(int req);
        int     a;
        int     steps;
        int     s;
        int     best;
        int     best_diff;
        int     old;
        int     rem;
        bit     found;
        reply_t r;
        a = 0;
        steps = 0;
        best = 0;
        best_diff = 0;
        found = 1'b0;
        while (a < HEAP && steps < HEAP)
        begin
            s = block_len(a);
            if (!hdr_mem[a][0] && s > req && (!found || (s - req) < best_diff))
            begin
                best = a;
                best_diff = s - req;
                found = 1'b1;
            end
            a = a + s + 1;
            steps++;
        end
        if (!found)
        begin
            r.status = ST_NO_FIT;
            r.paddr = 7'd0;
            return r;
        end
        old = block_len(best);
        rem = best + req + 1;
        hdr_mem[best] = {7'(req), 1'b1};
        if (rem < HEAP)
            hdr_mem[rem] = {7'(old - req - 1), 1'b0};
        r.status = ST_OK;
        r.paddr = 7'(best + 1);
        return r;
    endfunction

    function automatic reply_t release_block(int paddr);
        int     a;
        int     steps;
        int     s;
        int     nxt;
        reply_t r;
        a = 0;
        steps = 0;
        r.paddr = 7'd0;
        r.status = ST_NOT_BLOCK;
        if (paddr == 0)
            return r;
        while (a < HEAP && steps < HEAP)
        begin
            s = block_len(a);
            nxt = a + s + 1;
            if (a == paddr - 1)
            begin
                hdr_mem[a][0] = 1'b0;
                // absorb the following block when it is free
                if (nxt < HEAP && !hdr_mem[nxt][0])
                begin
                    hdr_mem[a] = {7'(s + block_len(nxt) + 1), 1'b0};
                    hdr_mem[nxt] = 8'h00;
                end
                r.status = ST_OK;
                return r;
            end
            a = nxt;
            steps++;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_clear();
            reply_q.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (cmd_is_free)
                    reply_q.push_back(release_block(int'(s_tdata[13:7])));
                else
                    reply_q.push_back(best_fit_alloc(int'(s_tdata[6:0])));
            end
            if (m_tvalid && m_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("unexpected item: status %0d payload_address %0d",
                           m_tuser, m_tdata[6:0]);
                    mismatches++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[6:0] !== want.paddr)
                    begin
                        $error("payload_address: expected %0d, got %0d",
                               want.paddr, m_tdata[6:0]);
                        mismatches++;
                    end
                end
            end
            outstanding <= reply_q.size();
        end
    end

endmodule

>>> sim/tb_best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// tb_best_fit_heap_allocator
// directed corner cases, then random allocate and free streams under input idling and output stalls
// ----------------------------------------------------------------------------
module tb_best_fit_heap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import bfha_pkg::*;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_FREE    = 1'b1;
    localparam int   PHASE_ITEMS = 275;
    localparam int   HOLD_CYCLES = 600;
    localparam int   TAIL_CYCLES = 2 * HEAP_BYTES_DEF + 16;
    localparam int   CYCLE_LIMIT = 2_000_000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // request_size[6:0], free_address[13:7], zero pad
    logic        s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // payload_address[6:0], zero pad
    logic [1:0]  m_tuser;   // status

    int          mismatches;
    int          outstanding;
    int          idle_pct;
    int          stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_taken;
    int          hold_left;
    int          cycles = 0;
    logic [6:0]  got_addr [$];
    int          got_taken = 0;
    logic [6:0]  live_addr [$];

    always #5 clk = ~clk;

    best_fit_heap_allocator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    best_fit_heap_allocator_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // addresses handed out, used to build well-formed free requests
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready && m_tuser == ST_OK && m_tdata[6:0] != 7'd0)
            got_addr.push_back(m_tdata[6:0]);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [6:0] req, input logic [6:0] faddr);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, faddr, req};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic random_item();
        int         r;
        int         k;
        logic       cmd;
        logic [6:0] req;
        logic [6:0] fa;
        while (got_taken < got_addr.size())
        begin
            live_addr.push_back(got_addr[got_taken]);
            got_taken++;
            if (live_addr.size() > 48)
                void'(live_addr.pop_front());
        end
        r = $urandom_range(99);
        req = 7'($urandom_range(127));
        fa = 7'($urandom_range(127));
        if (r < 55)
        begin
            cmd = CMD_ALLOC;
            k = $urandom_range(99);
            if (k < 70)
                req = 7'($urandom_range(7));
            else if (k < 95)
                req = 7'($urandom_range(31));
        end
        else if (r < 92 && live_addr.size() > 0)
        begin
            cmd = CMD_FREE;
            k = $urandom_range(live_addr.size() - 1);
            fa = live_addr[k];
            // sometimes keep it to free the same block again later
            if ($urandom_range(99) < 85)
                live_addr.delete(k);
        end
        else
        begin
            cmd = CMD_FREE;
        end
        send_item(cmd, req, fa);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 16'h0000;
        s_tuser = CMD_ALLOC;
        idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_FREE,  7'd0,   7'd0);
        send_item(CMD_FREE,  7'd127, 7'd1);
        send_item(CMD_ALLOC, 7'd127, 7'd127);
        send_item(CMD_ALLOC, 7'd126, 7'd0);
        send_item(CMD_ALLOC, 7'd0,   7'd127);
        send_item(CMD_FREE,  7'd0,   7'd127);
        send_item(CMD_FREE,  7'd0,   7'd1);
        send_item(CMD_ALLOC, 7'd9,   7'd0);
        send_item(CMD_ALLOC, 7'd0,   7'd0);
        send_item(CMD_ALLOC, 7'd9,   7'd0);
        send_item(CMD_ALLOC, 7'd0,   7'd0);
        send_item(CMD_FREE,  7'd0,   7'd1);
        send_item(CMD_FREE,  7'd0,   7'd12);
        send_item(CMD_ALLOC, 7'd5,   7'd127);
        send_item(CMD_FREE,  7'd127, 7'd11);
        send_item(CMD_FREE,  7'd0,   7'd12);
        send_item(CMD_FREE,  7'd0,   7'd22);
        send_item(CMD_FREE,  7'd0,   7'd7);
        send_item(CMD_FREE,  7'd0,   7'd3);
        send_item(CMD_ALLOC, 7'd105, 7'd0);
        send_item(CMD_FREE,  7'd0,   7'd22);
        send_item(CMD_FREE,  7'd0,   7'd1);
        send_item(CMD_ALLOC, 7'd127, 7'd0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 79;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 79;
                    hold_req <= 1'b1;
                end
                default:
                begin
                    idle_pct = 31;
                    stall_pct <= 31;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
